// ===== hw/rtl/rlg_pkg.sv =====
// Shared constants and types for the robust loss and gradient unit.
`timescale 1ns / 1ps

package rlg_pkg;

  // Default number of fraction bits of the fixed-point values.
  localparam int FRAC_BITS_DEF = 16;

  // Quotient bits produced by each divider and its latency in cycles.
  localparam int QUO_W   = 32;
  localparam int DIV_LAT = QUO_W + 1;

  // Reset value of the scale register (1.0 in Q16.16).
  localparam logic [30:0] NU_RESET = 31'd65536;

  // Loss criterion codes.
  typedef enum logic [2:0] {
    MODE_SQUARED  = 3'd0,
    MODE_L1       = 3'd1,
    MODE_L0       = 3'd2,
    MODE_HUBER    = 3'd3,
    MODE_BIWEIGHT = 3'd4,
    MODE_HINGE    = 3'd5
  } loss_mode_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_LOSS_MODE   = 2'd0,
    REG_SCALE_NU    = 2'd1,
    REG_SUP_COUNT   = 2'd2
  } reg_index_t;

  // Per-item context that travels beside the dividers.
  typedef struct packed {
    logic        valid;
    logic        use_div;
    logic        bw;
    logic        neg;
    logic [30:0] loss;
    logic [31:0] grad;
    logic        flag;
  } rlg_ctx_t;

endpackage

// ===== hw/rtl/rlg_if.sv =====
// Channel interfaces of the robust loss and gradient unit.
`timescale 1ns / 1ps

interface rlg_item_if;
  logic               valid;
  logic               ready;
  logic [15:0]        unit_index;
  logic signed [31:0] output_value;
  logic signed [31:0] target_value;

  modport source (output valid, unit_index, output_value, target_value, input ready);
  modport sink (input valid, unit_index, output_value, target_value, output ready);
endinterface

interface rlg_result_if;
  logic               valid;
  logic               ready;
  logic [30:0]        loss;
  logic signed [31:0] gradient;
  logic               saturated;

  modport source (output valid, loss, gradient, saturated, input ready);
  modport sink (input valid, loss, gradient, saturated, output ready);
endinterface

interface rlg_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/rlg_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
`timescale 1ns / 1ps

module rlg_div #(
  parameter int NUM_W = 48,
  parameter int DEN_W = 31
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [NUM_W-1:0]         num,
  input  logic [DEN_W-1:0]         den,
  output logic [rlg_pkg::QUO_W-1:0] quo,
  output logic                     ovf
);
  import rlg_pkg::*;

  localparam int W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

  logic [W-1:0]     rem [0:QUO_W-1];
  logic [DEN_W-1:0] dsr [0:QUO_W-1];
  logic [QUO_W-1:0] qa  [0:QUO_W];
  logic             ov  [0:QUO_W];

  // First stage: load and flag quotients that do not fit in QUO_W bits.
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= W'(num);
      dsr[0] <= den;
      qa[0]  <= '0;
      ov[0]  <= W'(num) >= (W'(den) << QUO_W);
    end
  end

  // One trial subtraction per stage, most significant bit first.
  for (genvar k = 1; k <= QUO_W; k++) begin : g_step
    localparam int B = QUO_W - k;
    logic [W-1:0] trial;
    logic         ge;

    assign trial = W'(dsr[k-1]) << B;
    assign ge    = rem[k-1] >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        qa[k] <= qa[k-1] | (QUO_W'(ge) << B);
        ov[k] <= ov[k-1];
      end
    end

    if (k < QUO_W) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem[k] <= ge ? rem[k-1] - trial : rem[k-1];
          dsr[k] <= dsr[k-1];
        end
      end
    end
  end

  assign quo = qa[QUO_W];
  assign ovf = ov[QUO_W];

endmodule

// ===== hw/rtl/robust_loss_gradient_unit.sv =====
// Robust loss and gradient unit: top level with the scoring pipeline.
`timescale 1ns / 1ps

// The unit takes one transaction per clock cycle while the output is not stalled
// and returns exactly one result per transaction, in order. A result passes
// through three front stages, a 33-stage radix-2 divider, four multiply stages
// for the biweight criterion and a second 33-stage divider, then the output
// register. The whole pipeline holds while a result waits at the output.
// Configuration writes are taken at any time but must only be issued while no
// transaction is in flight; the configuration port is always ready. Units whose
// index is at or above the supervised count score zero.

module robust_loss_gradient_unit #(
  parameter int FRAC_BITS = rlg_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  rlg_item_if.sink      item,
  rlg_result_if.source  result,
  rlg_cfg_if.sink       cfg
);
  import rlg_pkg::*;

  localparam int F       = FRAC_BITS;
  localparam int NUM_A_W = 32 + F;
  localparam int NUM_B_W = 2 * F + 5;
  localparam logic [31:0]  ONE   = 32'(1) << F;
  localparam logic [31:0]  HALF  = 32'(1) << (F - 1);
  localparam logic [F+1:0] THREE = (F + 2)'(3) << F;

  // Saturate a loss: big marks a value known to exceed 32 bits.
  function automatic logic [31:0] sat_loss(input logic [31:0] x, input logic big);
    logic [31:0] r;
    if (big || x[31]) r = {1'b1, 31'h7FFF_FFFF};
    else r = {1'b0, x[30:0]};
    return r;
  endfunction

  // Apply a sign to a magnitude and saturate to 32 signed bits.
  function automatic logic [32:0] sat_grad(input logic neg, input logic [31:0] mag,
                                           input logic big);
    logic [32:0] r;
    if (neg) begin
      if (big || mag > 32'h8000_0000) r = {1'b1, 32'h8000_0000};
      else r = {1'b0, 32'd0 - mag};
    end else begin
      if (big || mag[31]) r = {1'b1, 32'h7FFF_FFFF};
      else r = {1'b0, mag};
    end
    return r;
  endfunction

  // Configuration registers.
  loss_mode_t  loss_mode;
  logic [30:0] scale_nu;
  logic [15:0] supervised_count;
  logic        nu_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      loss_mode        <= MODE_SQUARED;
      scale_nu         <= NU_RESET;
      supervised_count <= '0;
    end else if (cfg.valid && cfg.ready) begin
      case (reg_index_t'(cfg.index))
        REG_LOSS_MODE: loss_mode        <= loss_mode_t'(cfg.data[2:0]);
        REG_SCALE_NU:  scale_nu         <= cfg.data[30:0];
        REG_SUP_COUNT: supervised_count <= cfg.data[15:0];
        default: ;
      endcase
    end
  end

  assign cfg.ready = 1'b1;
  assign nu_zero   = (scale_nu == '0);

  // Global advance: the pipeline moves whenever the output register is free.
  logic res_valid;
  logic en;

  assign en         = !res_valid || result.ready;
  assign item.ready = en;

  // Stage 1: input register.
  logic        p1_valid;
  logic [15:0] p1_unit;
  logic [31:0] p1_v;
  logic [31:0] p1_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (en) begin
      p1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_unit <= item.unit_index;
      p1_v    <= item.output_value;
      p1_t    <= item.target_value;
    end
  end

  // Stage 2: error magnitude and hinge margin.
  logic [32:0] e_w;
  logic [32:0] a_w;
  logic [33:0] vm_w;
  logic [33:0] tm_w;
  logic [34:0] h_w;
  logic        below_w;

  assign e_w     = {p1_v[31], p1_v} - {p1_t[31], p1_t};
  assign a_w     = e_w[32] ? 33'd0 - e_w : e_w;
  assign vm_w    = {{2{p1_v[31]}}, p1_v} - 34'(HALF);
  assign tm_w    = {{2{p1_t[31]}}, p1_t} - 34'(HALF);
  assign below_w = tm_w[33];
  assign h_w     = below_w ? 35'(scale_nu) + {vm_w[33], vm_w}
                           : 35'(scale_nu) - {vm_w[33], vm_w};

  logic        p2_valid;
  logic        p2_sup;
  logic        p2_neg;
  logic [31:0] p2_a;
  logic        p2_below;
  logic        p2_h_pos;
  logic        p2_h_big;
  logic [31:0] p2_h_lo;
  logic        p2_hnz;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else if (en) begin
      p2_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_sup   <= p1_unit < supervised_count;
      p2_neg   <= e_w[32];
      p2_a     <= a_w[31:0];
      p2_below <= below_w;
      p2_h_pos <= !h_w[34] && (h_w != '0);
      p2_h_big <= !h_w[34] && (|h_w[33:32]);
      p2_h_lo  <= h_w[31:0];
      p2_hnz   <= (tm_w[33] && !vm_w[33] && vm_w != '0) ||
                  (!tm_w[33] && tm_w != '0 && vm_w[33]);
    end
  end

  // Stage 3: squares and magnitude compare.
  logic        p3_valid;
  logic        p3_sup;
  logic        p3_neg;
  logic [31:0] p3_a;
  logic        p3_a_zero;
  logic        p3_a_lt_nu;
  logic        p3_below;
  logic        p3_h_pos;
  logic        p3_h_big;
  logic [31:0] p3_h_lo;
  logic        p3_hnz;
  logic [63:0] p3_aa;
  logic [63:0] p3_hh;

  always_ff @(posedge clk) begin
    if (rst) begin
      p3_valid <= 1'b0;
    end else if (en) begin
      p3_valid <= p2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p3_sup     <= p2_sup;
      p3_neg     <= p2_neg;
      p3_a       <= p2_a;
      p3_a_zero  <= (p2_a == '0);
      p3_a_lt_nu <= p2_a < {1'b0, scale_nu};
      p3_below   <= p2_below;
      p3_h_pos   <= p2_h_pos;
      p3_h_big   <= p2_h_big;
      p3_h_lo    <= p2_h_lo;
      p3_hnz     <= p2_hnz;
      p3_aa      <= 64'(p2_a) * 64'(p2_a);
      p3_hh      <= 64'(p2_h_lo) * 64'(p2_h_lo);
    end
  end

  // Results that need no division, and which dividers the item needs.
  logic [63:0] aa_sh;
  logic [63:0] hh_sh;
  logic [31:0] d_sl;
  logic [32:0] d_sg;
  rlg_ctx_t    d_ctx;

  assign aa_sh = p3_aa >> (F + 1);
  assign hh_sh = p3_hh >> (F + 1);

  always_comb begin
    d_ctx       = '0;
    d_ctx.valid = p3_valid;
    d_ctx.neg   = p3_neg;
    d_sl        = '0;
    d_sg        = '0;
    if (p3_sup) begin
      case (loss_mode)
        MODE_SQUARED: begin
          d_sl       = sat_loss(aa_sh[31:0], |aa_sh[63:32]);
          d_sg       = sat_grad(p3_neg, p3_a, 1'b0);
          d_ctx.loss = d_sl[30:0];
          d_ctx.grad = d_sg[31:0];
          d_ctx.flag = d_sl[31] | d_sg[32];
        end
        MODE_L1, MODE_L0: begin
          if (nu_zero) begin
            // Zero scale: the gradient division by zero saturates.
            d_sl       = sat_loss(p3_a, 1'b0);
            d_ctx.flag = 1'b1;
            if (loss_mode == MODE_L1) d_ctx.loss = d_sl[30:0];
            else d_ctx.loss = p3_a_zero ? '0 : ONE[30:0];
            if (p3_a_zero) d_ctx.grad = '0;
            else d_ctx.grad = p3_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
          end else begin
            d_ctx.use_div = 1'b1;
          end
        end
        MODE_HUBER: begin
          if (p3_a_lt_nu) begin
            d_ctx.use_div = 1'b1;
          end else begin
            d_sl       = sat_loss(p3_a - {2'b00, scale_nu[30:1]}, 1'b0);
            d_ctx.loss = d_sl[30:0];
            d_ctx.flag = d_sl[31];
            if (p3_a_zero) d_ctx.grad = '0;
            else d_ctx.grad = p3_neg ? 32'd0 - ONE : ONE;
          end
        end
        MODE_BIWEIGHT: begin
          if (nu_zero) d_ctx.loss = p3_a_zero ? '0 : ONE[30:0];
          else if (!p3_a_lt_nu) d_ctx.loss = ONE[30:0];
          else d_ctx.bw = 1'b1;
        end
        MODE_HINGE: begin
          if (nu_zero) begin
            d_ctx.loss = p3_hnz ? ONE[30:0] : '0;
          end else if (p3_h_pos) begin
            d_sl       = sat_loss(hh_sh[31:0], p3_h_big | (|hh_sh[63:32]));
            d_sg       = sat_grad(!p3_below, p3_h_lo, p3_h_big);
            d_ctx.loss = d_sl[30:0];
            d_ctx.grad = d_sg[31:0];
            d_ctx.flag = d_sl[31] | d_sg[32];
          end
        end
        default: ;
      endcase
    end
  end

  // First dividers: gradient or biweight ratio, and the quadratic loss.
  logic [QUO_W-1:0] quo_a;
  logic             ovf_a;
  logic [QUO_W-1:0] quo_l;
  logic             ovf_l;

  rlg_div #(.NUM_W(NUM_A_W), .DEN_W(31)) u_div_a (
    .clk (clk),
    .en  (en),
    .num ({p3_a, F'(0)}),
    .den (scale_nu),
    .quo (quo_a),
    .ovf (ovf_a)
  );

  rlg_div #(.NUM_W(64), .DEN_W(32)) u_div_l (
    .clk (clk),
    .en  (en),
    .num (p3_aa),
    .den ({scale_nu, 1'b0}),
    .quo (quo_l),
    .ovf (ovf_l)
  );

  // Context line beside the first dividers.
  rlg_ctx_t ctx_d [0:DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV_LAT; i++) ctx_d[i].valid <= 1'b0;
    end else if (en) begin
      ctx_d[0] <= d_ctx;
      for (int i = 1; i < DIV_LAT; i++) ctx_d[i] <= ctx_d[i-1];
    end
  end

  // Merge the divider results into the context.
  rlg_ctx_t    m_ctx;
  logic [31:0] m_sl;
  logic [32:0] m_sg;
  logic [F-1:0] u_w;

  assign u_w = quo_a[F-1:0];

  always_comb begin
    m_ctx = ctx_d[DIV_LAT-1];
    m_sl  = sat_loss(quo_l, ovf_l);
    m_sg  = sat_grad(ctx_d[DIV_LAT-1].neg, quo_a, ovf_a);
    if (ctx_d[DIV_LAT-1].use_div) begin
      m_ctx.loss = m_sl[30:0];
      m_ctx.grad = m_sg[31:0];
      m_ctx.flag = m_sl[31] | m_sg[32];
    end
  end

  // Biweight stage 1: u squared.
  rlg_ctx_t       b1_ctx;
  logic [F-1:0]   b1_u;
  logic [2*F-1:0] b1_uu;

  // Biweight stage 2: u2 * (3 - u2) and (1 - u2) squared.
  rlg_ctx_t       b2_ctx;
  logic [F-1:0]   b2_u;
  logic [F-1:0]   b2_u2;
  logic [2*F+1:0] b2_pq;
  logic [2*F+1:0] b2_pw;
  logic [F-1:0]   u2_w;
  logic [F:0]     w_w;

  // Biweight stage 3: loss product and u * w2.
  rlg_ctx_t       b3_ctx;
  logic [2*F+1:0] b3_pl;
  logic [2*F+1:0] b3_pm;

  // Biweight stage 4: loss and numerator of the gradient.
  rlg_ctx_t       b4_ctx;
  logic [F+4:0]   b4_m;
  logic [2*F+4:0] m6_w;
  rlg_ctx_t       b4_next;

  assign u2_w = b1_uu[2*F-1:F];
  assign w_w  = (F + 1)'(ONE) - {1'b0, u2_w};
  assign m6_w = ((2 * F + 5)'(b3_pm) << 2) + ((2 * F + 5)'(b3_pm) << 1);

  always_comb begin
    b4_next = b3_ctx;
    if (b3_ctx.bw) b4_next.loss = 31'(b3_pl[2*F+1:F]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_ctx.valid <= 1'b0;
      b2_ctx.valid <= 1'b0;
      b3_ctx.valid <= 1'b0;
      b4_ctx.valid <= 1'b0;
    end else if (en) begin
      b1_ctx <= m_ctx;
      b2_ctx <= b1_ctx;
      b3_ctx <= b2_ctx;
      b4_ctx <= b4_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_u  <= u_w;
      b1_uu <= (2 * F)'(u_w) * (2 * F)'(u_w);
      b2_u  <= b1_u;
      b2_u2 <= u2_w;
      b2_pq <= (2 * F + 2)'(u2_w) * (2 * F + 2)'(THREE - (F + 2)'(u2_w));
      b2_pw <= (2 * F + 2)'(w_w) * (2 * F + 2)'(w_w);
      b3_pl <= (2 * F + 2)'(b2_u2) * (2 * F + 2)'(THREE - b2_pq[2*F+1:F]);
      b3_pm <= (2 * F + 2)'(b2_u) * (2 * F + 2)'(b2_pw[2*F+1:F]);
      b4_m  <= m6_w[2*F+4:F];
    end
  end

  // Second divider: biweight gradient.
  logic [QUO_W-1:0] quo_b;
  logic             ovf_b;

  rlg_div #(.NUM_W(NUM_B_W), .DEN_W(31)) u_div_b (
    .clk (clk),
    .en  (en),
    .num ({b4_m, F'(0)}),
    .den (scale_nu),
    .quo (quo_b),
    .ovf (ovf_b)
  );

  rlg_ctx_t ctx_e [0:DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV_LAT; i++) ctx_e[i].valid <= 1'b0;
    end else if (en) begin
      ctx_e[0] <= b4_ctx;
      for (int i = 1; i < DIV_LAT; i++) ctx_e[i] <= ctx_e[i-1];
    end
  end

  // Final merge and output register.
  rlg_ctx_t    f_ctx;
  logic [32:0] f_sg;

  always_comb begin
    f_ctx = ctx_e[DIV_LAT-1];
    f_sg  = sat_grad(ctx_e[DIV_LAT-1].neg, quo_b, ovf_b);
    if (ctx_e[DIV_LAT-1].bw) begin
      f_ctx.grad = f_sg[31:0];
      f_ctx.flag = f_sg[32];
    end
  end

  logic [30:0] res_loss;
  logic [31:0] res_grad;
  logic        res_flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= f_ctx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_loss <= f_ctx.loss;
      res_grad <= f_ctx.grad;
      res_flag <= f_ctx.flag;
    end
  end

  assign result.valid     = res_valid;
  assign result.loss      = res_loss;
  assign result.gradient  = res_grad;
  assign result.saturated = res_flag;

  // No result may be offered in the cycle after reset.
  a_reset_clears: assert property (@(posedge clk) rst |=> !result.valid)
    else $error("result valid right after reset");

  // A stalled output freezes the tail of the pipeline.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.ready) |=> $stable(ctx_e[DIV_LAT-1]))
    else $error("pipeline moved during a stall");

  // On the biweight path the first quotient is a fraction below one.
  a_bw_ratio: assert property (@(posedge clk) disable iff (rst)
    (ctx_d[DIV_LAT-1].valid && ctx_d[DIV_LAT-1].bw) |-> (!ovf_a && quo_a < ONE))
    else $error("biweight ratio out of range");

  // The biweight loss stays below three.
  a_bw_loss: assert property (@(posedge clk) disable iff (rst)
    (b4_ctx.valid && b4_ctx.bw) |-> (b4_ctx.loss < 31'(THREE)))
    else $error("biweight loss out of range");

  // An item never needs both division paths.
  a_path_excl: assert property (@(posedge clk) disable iff (rst)
    ctx_d[0].valid |-> !(ctx_d[0].use_div && ctx_d[0].bw))
    else $error("item marked for both division paths");

endmodule

// ===== tb/sv/robust_loss_gradient_unit_tb.sv =====
// Self-checking testbench for the robust loss and gradient unit.
`timescale 1ns / 1ps

module robust_loss_gradient_unit_tb;
  import rlg_pkg::*;

  localparam int F = 16;
  localparam int DRAIN_CYCLES = 120;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [30:0] loss;
    logic [31:0] grad;
    logic        sat;
  } score_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rlg_item_if   item_ch();
  rlg_result_if result_ch();
  rlg_cfg_if    cfg_ch();

  robust_loss_gradient_unit u_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch.sink),
    .result (result_ch.source),
    .cfg    (cfg_ch.sink)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow copy of the configuration registers.
  logic [2:0]  mode_sh;
  logic [30:0] nu_sh;
  logic [15:0] count_sh;

  score_t expected_scores[$];
  int     fail_count = 0;
  int     idle_cycles = 0;
  bit     allow_gaps = 1'b1;
  bit     hold_req = 1'b0;
  bit     hold_done = 1'b0;

  // Clip a loss magnitude to 31 bits.
  function automatic logic [30:0] clip_loss(input logic [127:0] x, inout logic fl);
    if (x > 128'h7FFFFFFF) begin
      fl = 1'b1;
      return 31'h7FFFFFFF;
    end
    return x[30:0];
  endfunction

  // Apply a sign to a magnitude and clip to the signed 32-bit range.
  function automatic logic [31:0] clip_grad(input logic neg, input logic [127:0] mag,
                                            inout logic fl);
    logic [31:0] m;
    if (neg) begin
      if (mag > 128'h80000000) begin
        fl = 1'b1;
        mag = 128'h80000000;
      end
      m = mag[31:0];
      return -m;
    end
    if (mag > 128'h7FFFFFFF) begin
      fl = 1'b1;
      mag = 128'h7FFFFFFF;
    end
    return mag[31:0];
  endfunction

  // Loss and gradient for one unit under the shadow configuration.
  function automatic score_t score_unit(input logic [15:0] idx, input logic signed [31:0] v,
                                        input logic signed [31:0] t);
    score_t r;
    logic signed [63:0] e, vm, tm, h, half;
    logic [127:0] a, nu, one, u, u2, q, w, w2, m, hu;
    logic neg, below, fl;
    e = 64'(v) - 64'(t);
    neg = e < 0;
    a = neg ? 128'(-e) : 128'(e);
    nu = 128'(nu_sh);
    one = 128'(1) << F;
    fl = 1'b0;
    r = '0;
    if (idx < count_sh) begin
      case (mode_sh)
        MODE_SQUARED: begin
          r.loss = clip_loss((a * a) >> (F + 1), fl);
          r.grad = clip_grad(neg, a, fl);
        end
        MODE_L1, MODE_L0: begin
          if (nu == 0) begin
            if (mode_sh == MODE_L1) r.loss = clip_loss(a, fl);
            else r.loss = (a != 0) ? one[30:0] : '0;
            fl = 1'b1;
            r.grad = (a != 0) ? clip_grad(neg, {128{1'b1}}, fl) : '0;
          end else begin
            r.loss = clip_loss((a * a) / (2 * nu), fl);
            r.grad = clip_grad(neg, (a << F) / nu, fl);
          end
        end
        MODE_HUBER: begin
          if (a < nu) begin
            r.loss = clip_loss((a * a) / (2 * nu), fl);
            r.grad = clip_grad(neg, (a << F) / nu, fl);
          end else begin
            r.loss = clip_loss(a - (nu >> 1), fl);
            r.grad = (a != 0) ? clip_grad(neg, one, fl) : '0;
          end
        end
        MODE_BIWEIGHT: begin
          if (nu == 0) r.loss = (a != 0) ? one[30:0] : '0;
          else if (a >= nu) r.loss = one[30:0];
          else begin
            u = (a << F) / nu;
            u2 = (u * u) >> F;
            q = (u2 * (3 * one - u2)) >> F;
            w = one - u2;
            w2 = (w * w) >> F;
            m = (6 * u * w2) >> F;
            r.loss = clip_loss((u2 * (3 * one - q)) >> F, fl);
            r.grad = clip_grad(neg, (m << F) / nu, fl);
          end
        end
        MODE_HINGE: begin
          half = 64'sd1 <<< (F - 1);
          tm = 64'(t) - half;
          vm = 64'(v) - half;
          if (nu == 0) begin
            r.loss = ((tm < 0 && vm > 0) || (tm > 0 && vm < 0)) ? one[30:0] : '0;
          end else begin
            below = 64'(t) < half;
            h = below ? $signed(64'(nu_sh)) + vm : $signed(64'(nu_sh)) - vm;
            if (h > 0) begin
              hu = 128'(h);
              r.loss = clip_loss((hu * hu) >> (F + 1), fl);
              r.grad = clip_grad(!below, hu, fl);
            end
          end
        end
        default: ;
      endcase
    end
    r.sat = fl;
    return r;
  endfunction

  // Random gap between transactions, taken about a quarter of the time.
  task automatic maybe_gap();
    int n;
    if (allow_gaps && $urandom_range(3) == 0) begin
      n = $urandom_range(5, 1);
      item_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Offer one transaction and wait until it is accepted.
  task automatic send_item(input logic [15:0] idx, input logic [31:0] v, input logic [31:0] t);
    item_ch.valid <= 1'b1;
    item_ch.unit_index <= idx;
    item_ch.output_value <= v;
    item_ch.target_value <= t;
    do @(posedge clk); while (!item_ch.ready);
    expected_scores.push_back(score_unit(idx, v, t));
    maybe_gap();
  endtask

  // Wait for the pipeline to empty, then write one register.
  task automatic write_reg(input reg_index_t ri, input logic [31:0] val);
    item_ch.valid <= 1'b0;
    wait (expected_scores.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= ri;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (ri)
      REG_LOSS_MODE: mode_sh = val[2:0];
      REG_SCALE_NU:  nu_sh = val[30:0];
      REG_SUP_COUNT: count_sh = val[15:0];
      default: ;
    endcase
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'(int'($urandom_range(2 * 65536)) - 65536);
      2: return 32'(int'($urandom_range(8 * 65536)) - 4 * 65536);
      3: return {$urandom_range(1) ? 1'b1 : 1'b0, 31'(0)} | 32'($urandom_range(3));
      default: return 32'($urandom_range(65536));
    endcase
  endfunction

  function automatic logic [30:0] rand_nu();
    case ($urandom_range(4))
      0: return '0;
      1: return 31'h7FFFFFFF;
      2: return 31'($urandom);
      default: return 31'($urandom_range(4 * 65536, 1));
    endcase
  endfunction

  // Unsupervised units and the reset configuration.
  task automatic test_reset_state();
    send_item(16'd0, 32'h0001_0000, 32'h0);
    send_item(16'hFFFF, 32'h8000_0000, 32'h7FFF_FFFF);
  endtask

  // Each criterion at extreme operands, with zero scale for odd mode codes and 1.0 for even ones.
  task automatic test_directed();
    logic [2:0] md;
    write_reg(REG_SUP_COUNT, 32'hFFFF);
    for (int k = 0; k < 7; k++) begin
      md = 3'(k);
      write_reg(REG_LOSS_MODE, 32'(md));
      write_reg(REG_SCALE_NU, (k % 2) ? 32'h0 : 32'h0001_0000);
      send_item(16'd0, 32'h7FFF_FFFF, 32'h8000_0000);
      send_item(16'd1, 32'h8000_0000, 32'h7FFF_FFFF);
      send_item(16'hFFFE, 32'h0000_8000, 32'h0000_8000);
    end
    write_reg(REG_SCALE_NU, 32'h7FFF_FFFF);
    send_item(16'd5, 32'h0, 32'h0);
    send_item(16'hFFFF, 32'h1234_5678, 32'h0);
  endtask

  // Random phases over all loss modes with random scales and counts, one with a long output hold-off.
  task automatic test_random();
    int n;
    for (int p = 0; p < 24; p++) begin
      write_reg(REG_LOSS_MODE, (p < 21) ? 32'(p % 6) : $urandom_range(7));
      write_reg(REG_SCALE_NU, 32'(rand_nu()));
      write_reg(REG_SUP_COUNT, ($urandom_range(3) == 0) ? $urandom_range(65535) : 32'hFFFF);
      allow_gaps = (p < 20);
      if (p == 3) hold_req = 1'b1;
      n = 50;
      for (int i = 0; i < n; i++)
        send_item(16'($urandom), rand_value(), rand_value());
    end
  endtask

  // Output ready with random stalls and one long hold-off.
  initial begin
    result_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        result_ch.ready <= 1'b0;
        hold_done = 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else if (allow_gaps && $urandom_range(5) == 0) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(5, 1) - 1) @(posedge clk);
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // Compare each result with the oldest expectation.
  always @(posedge clk) begin
    score_t exp_s;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_scores.size() == 0) begin
        $display("%0t unexpected result loss=%h grad=%h sat=%b", $time, result_ch.loss,
                 result_ch.gradient, result_ch.saturated);
        fail_count++;
      end else begin
        exp_s = expected_scores.pop_front();
        if (exp_s.loss !== result_ch.loss) begin
          $display("%0t loss expected %h actual %h", $time, exp_s.loss, result_ch.loss);
          fail_count++;
        end
        if (exp_s.grad !== result_ch.gradient) begin
          $display("%0t gradient expected %h actual %h", $time, exp_s.grad,
                   result_ch.gradient);
          fail_count++;
        end
        if (exp_s.sat !== result_ch.saturated) begin
          $display("%0t saturated expected %b actual %b", $time, exp_s.sat,
                   result_ch.saturated);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted transaction.
  always @(posedge clk) begin
    if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    item_ch.valid <= 1'b0;
    item_ch.unit_index <= '0;
    item_ch.output_value <= '0;
    item_ch.target_value <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= REG_LOSS_MODE;
    cfg_ch.data <= '0;
    mode_sh = MODE_SQUARED;
    nu_sh = NU_RESET;
    count_sh = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_directed();
    test_random();
    item_ch.valid <= 1'b0;
    wait (expected_scores.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
